@@ rtl/core/prc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants of the pixel radiometric calibrator.
// ----------------------------------------------------------------------------
package prc_pkg;

   localparam int WeightEntriesDefault = 256;

   // Pixel status codes.
   localparam logic [2:0] ST_VALID = 3'd0;
   localparam logic [2:0] ST_NULL  = 3'd1;
   localparam logic [2:0] ST_LRS   = 3'd2;
   localparam logic [2:0] ST_LIS   = 3'd3;
   localparam logic [2:0] ST_HIS   = 3'd4;
   localparam logic [2:0] ST_HRS   = 3'd5;

   // Request kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_CALIB = 1'b1;

   // Register indexes.
   localparam logic [2:0] CSR_CALIB_SCALE  = 3'd0;
   localparam logic [2:0] CSR_EXPOSURE     = 3'd1;
   localparam logic [2:0] CSR_DARK_INV     = 3'd2;
   localparam logic [2:0] CSR_DARK_IS_BYTE = 3'd3;
   localparam logic [2:0] CSR_IOF_MODE     = 3'd4;

   localparam logic [31:0] CALIB_SCALE_RST = 32'd65536;
   localparam logic [23:0] EXPOSURE_RST    = 24'd25600;
   localparam logic [23:0] DARK_INV_RST    = 24'd65536;

   localparam int DIV_BITS = 48;

   localparam logic [47:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] NEG_LIMIT = 48'h8000_0000_0000;

   typedef struct packed {
      logic [2:0]  status;
      logic        neg;
      logic        sat;
      logic [23:0] den;
   } side_type;

endpackage

@@ rtl/core/pixel_radiometric_calibrator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_radiometric_calibrator
// Bit-weight lookup, dark subtraction, gain and exposure scaling per pixel.
// ----------------------------------------------------------------------------
// Pipeline: 56 register stages (seven arithmetic, 48 one-bit divider, one output).
// Throughput: one request per cycle; the whole pipeline stalls only while a
// result waits at the output. Load requests write the table and leave a bubble.
// Reset (synchronous): registers take their defaults and the pipeline empties; the
// table is then filled with entry i = i * 256 for each i, with req_ready low.
module pixel_radiometric_calibrator
   import prc_pkg::*;
#(
   parameter int WEIGHT_ENTRIES = WeightEntriesDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [7:0]         req_pixel_dn,
   input  logic [2:0]         req_pixel_class,
   input  logic signed [23:0] req_dark_value,
   input  logic               req_dark_special,
   input  logic [23:0]        req_gain_factor,
   input  logic               req_gain_special,
   input  logic               req_shutter_special,
   input  logic [23:0]        req_line_shutter_ms,
   input  logic [7:0]         req_table_index,
   input  logic [23:0]        req_table_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [47:0] rsp_cal_value,
   output logic [2:0]         rsp_pixel_status,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int IW = (WEIGHT_ENTRIES > 1) ? $clog2(WEIGHT_ENTRIES) : 1;
   localparam logic [31:0] LAST_IDX = 32'(WEIGHT_ENTRIES - 1);
   localparam logic [31:0] ENTRIES  = 32'(WEIGHT_ENTRIES);

   // Configuration registers.
   logic [31:0] calib_scale_ff;
   logic [23:0] exposure_ff;
   logic [23:0] dark_inv_ff;
   logic        dark_is_byte_ff;
   logic        iof_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_scale_ff  <= CALIB_SCALE_RST;
         exposure_ff     <= EXPOSURE_RST;
         dark_inv_ff     <= DARK_INV_RST;
         dark_is_byte_ff <= 1'b1;
         iof_mode_ff     <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CALIB_SCALE:  calib_scale_ff  <= csr_wdata;
            CSR_EXPOSURE:     exposure_ff     <= csr_wdata[23:0];
            CSR_DARK_INV:     dark_inv_ff     <= csr_wdata[23:0];
            CSR_DARK_IS_BYTE: dark_is_byte_ff <= csr_wdata[0];
            CSR_IOF_MODE:     iof_mode_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic out_vld_ff;
   logic fill_busy_ff;
   logic adv;
   logic accept;

   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv && !fill_busy_ff;
   assign accept    = req_valid && req_ready;

   // ---------------- Stage 0: classify, table addresses ----------------
   logic [31:0] dn_a32, dk_a32;
   logic [24:0] den25;
   logic [2:0]  status_in;
   logic        calib_in, load_in;

   always_comb begin
      dn_a32 = 32'(req_pixel_dn);
      if (dn_a32 > LAST_IDX) begin
         dn_a32 = LAST_IDX;
      end
      if (req_dark_value[23]) begin
         dk_a32 = 32'd0;
      end else begin
         dk_a32 = 32'(req_dark_value[22:8]);
      end
      if (dk_a32 > LAST_IDX) begin
         dk_a32 = LAST_IDX;
      end
      den25 = {1'b0, exposure_ff} - {1'b0, req_line_shutter_ms};
      if (req_pixel_class != ST_VALID) begin
         status_in = (req_pixel_class > ST_HRS) ? ST_NULL : req_pixel_class;
      end else if (req_dark_special || req_gain_special || req_shutter_special ||
                   den25[24] || den25 == 25'd0) begin
         status_in = ST_NULL;
      end else begin
         status_in = ST_VALID;
      end
      calib_in = accept && (req_type == REQ_CALIB);
      load_in  = accept && (req_type == REQ_LOAD) && (32'(req_table_index) < ENTRIES);
   end

   // Weight table. After reset a fill pass writes the identity weights.
   logic [23:0]   wt_mem [WEIGHT_ENTRIES];
   logic [IW-1:0] wr_idx;
   logic [IW-1:0] fill_idx_ff;

   assign wr_idx = IW'(req_table_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_busy_ff <= 1'b1;
         fill_idx_ff  <= '0;
      end else if (fill_busy_ff) begin
         if (fill_idx_ff == LAST_IDX[IW-1:0]) begin
            fill_busy_ff <= 1'b0;
         end
         fill_idx_ff <= fill_idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (fill_busy_ff) begin
         wt_mem[fill_idx_ff] <= 24'({fill_idx_ff, 8'd0});
      end else if (load_in) begin
         wt_mem[wr_idx] <= req_table_value;
      end
   end

   // ---------------- Stage 1 ----------------
   logic               vld1_ff;
   logic [2:0]         status1_ff;
   logic [23:0]        den1_ff;
   logic signed [23:0] dark1_ff;
   logic [23:0]        gain1_ff;
   logic [23:0]        rdn_ff, rdk_ff;
   logic [23:0]        dnw1, dkw1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= calib_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status1_ff <= status_in;
         den1_ff    <= den25[23:0];
         dark1_ff   <= req_dark_value;
         gain1_ff   <= req_gain_factor;
         rdn_ff     <= wt_mem[dn_a32[IW-1:0]];
         rdk_ff     <= wt_mem[dk_a32[IW-1:0]];
      end
   end

   assign dnw1 = rdn_ff;
   assign dkw1 = rdk_ff;

   // ---------------- Stage 2: scaled dark product ----------------
   logic               vld2_ff;
   logic [2:0]         status2_ff;
   logic [23:0]        den2_ff, gain2_ff, dnw2_ff, dkw2_ff;
   logic signed [48:0] prod2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status2_ff <= status1_ff;
         den2_ff    <= den1_ff;
         gain2_ff   <= gain1_ff;
         dnw2_ff    <= dnw1;
         dkw2_ff    <= dkw1;
         prod2_ff   <= dark1_ff * $signed({1'b0, dark_inv_ff});
      end
   end

   // ---------------- Stage 3: dark current and difference ----------------
   logic               vld3_ff;
   logic [2:0]         status3_ff;
   logic [23:0]        den3_ff, gain3_ff;
   logic signed [34:0] diff3_ff;
   logic signed [48:0] biased;
   logic signed [32:0] dc;

   always_comb begin
      biased = prod2_ff + 49'sd32768;
      if (dark_is_byte_ff) begin
         dc = $signed({9'd0, dkw2_ff});
      end else begin
         dc = biased[48:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else if (adv) begin
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status3_ff <= status2_ff;
         den3_ff    <= den2_ff;
         gain3_ff   <= gain2_ff;
         diff3_ff   <= $signed({11'd0, dnw2_ff}) - $signed({{2{dc[32]}}, dc});
      end
   end

   // ---------------- Stage 4: gain ----------------
   logic               vld4_ff;
   logic [2:0]         status4_ff;
   logic [23:0]        den4_ff;
   logic signed [59:0] e4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
      end else if (adv) begin
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status4_ff <= status3_ff;
         den4_ff    <= den3_ff;
         e4_ff      <= diff3_ff * $signed({1'b0, gain3_ff});
      end
   end

   // ---------------- Stage 5: magnitude times calib_scale, two halves ----------------
   logic        vld5_ff;
   logic [2:0]  status5_ff;
   logic [23:0] den5_ff;
   logic        neg5_ff;
   logic [63:0] p0_ff;
   logic [58:0] p1_ff;
   logic [59:0] mag4;

   assign mag4 = e4_ff[59] ? 60'(-e4_ff) : 60'(e4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
      end else if (adv) begin
         vld5_ff <= vld4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status5_ff <= status4_ff;
         den5_ff    <= den4_ff;
         neg5_ff    <= e4_ff[59];
         p0_ff      <= 64'(mag4[31:0]) * 64'(calib_scale_ff);
         p1_ff      <= 59'(mag4[58:32]) * 59'(calib_scale_ff);
      end
   end

   // ---------------- Stage 6: combine, drop the 2^16 of the divisor ----------------
   logic        vld6_ff;
   logic [2:0]  status6_ff;
   logic [23:0] den6_ff;
   logic        neg6_ff;
   logic [74:0] np6_ff;
   logic [90:0] nsum;

   assign nsum = {p1_ff, 32'd0} + {27'd0, p0_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
      end else if (adv) begin
         vld6_ff <= vld5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status6_ff <= status5_ff;
         den6_ff    <= den5_ff;
         neg6_ff    <= neg5_ff;
         np6_ff     <= nsum[90:16];
      end
   end

   // ---------------- Stage 7 and divider ----------------
   // A quotient of 2^48 or more is caught here; the divider then only
   // produces the low 48 quotient bits, one per stage.
   logic        vld_ff  [DIV_BITS+1];
   side_type    side_ff [DIV_BITS+1];
   logic [23:0] rem_ff  [DIV_BITS+1];
   logic [47:0] w_ff    [DIV_BITS+1];
   side_type    side_in;

   always_comb begin
      side_in.den    = den6_ff;
      side_in.neg    = neg6_ff;
      side_in.sat    = np6_ff[74:48] >= {3'd0, den6_ff};
      side_in.status = status6_ff;
      if (status6_ff == ST_VALID && iof_mode_ff && neg6_ff && calib_scale_ff != 32'd0) begin
         side_in.status = ST_LRS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= vld6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         rem_ff[0]  <= np6_ff[71:48];
         w_ff[0]    <= np6_ff[47:0];
      end
   end

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      logic [24:0] trial;
      logic        take;
      logic [24:0] diff_t;

      assign trial  = {rem_ff[k], w_ff[k][DIV_BITS-1]};
      assign take   = trial >= {1'b0, side_ff[k].den};
      assign diff_t = trial - {1'b0, side_ff[k].den};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k+1] <= side_ff[k];
            rem_ff[k+1]  <= take ? diff_t[23:0] : trial[23:0];
            w_ff[k+1]    <= {w_ff[k][DIV_BITS-2:0], take};
         end
      end
   end

   // ---------------- Output register: saturation and sign ----------------
   logic signed [47:0] cal_in;
   logic signed [47:0] cal_ff;
   logic [2:0]         status_out_ff;
   logic [47:0]        q;
   side_type           sf;

   always_comb begin
      sf = side_ff[DIV_BITS];
      q  = w_ff[DIV_BITS];
      if (sf.neg) begin
         if (sf.sat || q > NEG_LIMIT) begin
            q = NEG_LIMIT;
         end
         cal_in = $signed(48'd0 - q);
      end else begin
         if (sf.sat || q > POS_LIMIT) begin
            q = POS_LIMIT;
         end
         cal_in = $signed(q);
      end
      if (sf.status != ST_VALID) begin
         cal_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[DIV_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cal_ff        <= cal_in;
         status_out_ff <= sf.status;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_cal_value    = cal_ff;
   assign rsp_pixel_status = status_out_ff;

`ifndef SYNTHESIS
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_status != ST_VALID |-> rsp_cal_value == 48'sd0)
      else $error("special status with nonzero value");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_status <= ST_HRS)
      else $error("status code out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cal_value)
      && $stable(rsp_pixel_status))
      else $error("stalled result changed");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken during stall");
`endif

endmodule
